// ----- rtl/u2d_pkg.sv -----
package u2d_pkg;

    localparam int VALUE_W        = 32;
    localparam int WIDTH_W        = 8;
    localparam int CHAR_W         = 6;
    localparam int DIGITS         = 10;
    localparam int BCD_W          = 4 * DIGITS;
    localparam int MAX_CHARS_DEF  = 15;

    // Double-dabble schedule: one shift per input bit, split evenly over stages
    localparam int DD_STEPS_PER_STAGE = 4;
    localparam int DD_STAGES          = VALUE_W / DD_STEPS_PER_STAGE;

    localparam logic [CHAR_W-1:0] DIGIT_BASE = CHAR_W'(48);

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
        logic [WIDTH_W-1:0] min_width;
    } u2d_dd_t;

    // One double-dabble step: correct every digit of 5 or more, then shift left
    function automatic u2d_dd_t dd_step(input u2d_dd_t x);
        u2d_dd_t y;
        logic [3:0] dig;
        y = x;
        for (int i = 0; i < DIGITS; i++)
        begin
            dig = x.bcd[4*i +: 4];
            if (dig >= 4'd5)
            begin
                y.bcd[4*i +: 4] = dig + 4'd3;
            end
        end
        y.bcd = {y.bcd[BCD_W-2:0], x.bin[VALUE_W-1]};
        y.bin = {x.bin[VALUE_W-2:0], 1'b0};
        return y;
    endfunction

endpackage

// ----- rtl/uint_to_decimal_ascii.sv -----
// Unsigned 32-bit binary to decimal ASCII text, one character per output item.
//
// Input channel: value and min_width, accepted on a clock edge with in_valid
// high and in_stall low. Output channel: digit_char, last and empty_res,
// taken on an edge with out_valid high and out_stall low.
// Digits come most significant first, left-padded with '0' up to min_width,
// which saturates at MAX_CHARS. The final character carries last. Zero with a
// zero width gives one item with empty_res and last set and digit_char zero.
//
// Path: the input edge loads the first of eight double-dabble stages of four
// shift steps each; the item then passes through the remaining stages, the
// serializer and the output register.
// Throughput: one character per cycle unless out_stall holds the output. The
// serializer takes a new item only as it emits the last character of the one
// before; meanwhile the conversion stages keep taking items until they fill.
// Reset clears all valid bits; payload registers are left as they are.
// A stalled output holds its item; backpressure travels stage by stage to
// in_stall, so no item is dropped or repeated.
module uint_to_decimal_ascii #(
    parameter int MAX_CHARS = u2d_pkg::MAX_CHARS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [u2d_pkg::VALUE_W-1:0] value,
    input  logic [u2d_pkg::WIDTH_W-1:0] min_width,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [u2d_pkg::CHAR_W-1:0]  digit_char,
    output logic                        last,
    output logic                        empty_res
);
    import u2d_pkg::*;

    // Stage k feeds stage k+1; index DD_STAGES is the serializer input
    logic    st_valid [DD_STAGES+1];
    u2d_dd_t st_data  [DD_STAGES+1];
    logic    st_stall [DD_STAGES+1];

    // Start with an empty BCD field and the binary value in the shift register
    assign st_valid[0]        = in_valid;
    assign st_data[0].bcd     = '0;
    assign st_data[0].bin     = value;
    assign st_data[0].min_width = min_width;
    assign in_stall           = st_stall[0];

    for (genvar k = 0; k < DD_STAGES; k++)
    begin : g_dd
        u2d_dd_stage u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (st_valid[k]),
            .up_data    (st_data[k]),
            .up_stall   (st_stall[k]),
            .down_valid (st_valid[k+1]),
            .down_data  (st_data[k+1]),
            .down_stall (st_stall[k+1])
        );
    end

    // Walk the digits out one character per cycle while the output is not stalled
    u2d_ser #(
        .MAX_CHARS (MAX_CHARS)
    ) u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (st_valid[DD_STAGES]),
        .up_data    (st_data[DD_STAGES]),
        .up_stall   (st_stall[DD_STAGES]),
        .out_valid  (out_valid),
        .digit_char (digit_char),
        .last       (last),
        .empty_res  (empty_res),
        .out_stall  (out_stall)
    );

endmodule

// ----- rtl/u2d_dd_stage.sv -----
module u2d_dd_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    input  u2d_pkg::u2d_dd_t up_data,
    output logic             up_stall,
    output logic             down_valid,
    output u2d_pkg::u2d_dd_t down_data,
    input  logic             down_stall
);
    import u2d_pkg::*;

    logic    valid_reg;
    u2d_dd_t data_reg;
    u2d_dd_t data_next;

    // Run this stage's share of the shift-and-correct steps
    always_comb
    begin
        data_next = up_data;
        for (int s = 0; s < DD_STEPS_PER_STAGE; s++)
        begin
            data_next = dd_step(data_next);
        end
    end

    // Hold while this stage is full and the next stage stalls
    assign up_stall   = valid_reg && down_stall;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/u2d_ser.sv -----
module u2d_ser #(
    parameter int MAX_CHARS = u2d_pkg::MAX_CHARS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    input  u2d_pkg::u2d_dd_t            up_data,
    output logic                        up_stall,
    output logic                        out_valid,
    output logic [u2d_pkg::CHAR_W-1:0]  digit_char,
    output logic                        last,
    output logic                        empty_res,
    input  logic                        out_stall
);
    import u2d_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHARS + 1);
    localparam int POS_W = $clog2(MAX_CHARS);
    localparam int IDX_W = $clog2(DIGITS);

    logic [3:0]        digs_reg [DIGITS];
    logic [POS_W-1:0]  pos_reg;
    logic              busy_reg;
    logic              empty_pend_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] digit_char_reg;
    logic              last_reg;
    logic              empty_res_reg;

    logic [CNT_W-1:0]  wcap;
    logic [CNT_W-1:0]  ndig;
    logic [CNT_W-1:0]  nchars;
    logic              emit;
    logic              finish;
    logic              load;
    logic [3:0]        cur_dig;

    // Character count of the arriving item: significant digits or capped width
    always_comb
    begin
        if (up_data.min_width > WIDTH_W'(MAX_CHARS))
        begin
            wcap = CNT_W'(MAX_CHARS);
        end
        else
        begin
            wcap = up_data.min_width[CNT_W-1:0];
        end
        ndig = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (up_data.bcd[4*i +: 4] != 4'd0)
            begin
                ndig = CNT_W'(i + 1);
            end
        end
        nchars = (ndig > wcap) ? ndig : wcap;
    end

    // Positions above the top digit are padding zeros
    always_comb
    begin
        if (pos_reg < POS_W'(DIGITS))
        begin
            cur_dig = digs_reg[pos_reg[IDX_W-1:0]];
        end
        else
        begin
            cur_dig = 4'd0;
        end
    end

    assign emit     = busy_reg && (!out_valid_reg || !out_stall);
    assign finish   = emit && (pos_reg == '0);
    assign up_stall = busy_reg && !finish;
    assign load     = up_valid && !up_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                digs_reg[i] <= up_data.bcd[4*i +: 4];
            end
            empty_pend_reg <= (nchars == '0);
            if (nchars == '0)
            begin
                pos_reg <= '0;
            end
            else
            begin
                pos_reg <= POS_W'(nchars - CNT_W'(1));
            end
        end
        else if (emit && !finish)
        begin
            pos_reg <= pos_reg - POS_W'(1);
        end
        if (emit)
        begin
            digit_char_reg <= empty_pend_reg ? '0 : (DIGIT_BASE + CHAR_W'(cur_dig));
            last_reg       <= (pos_reg == '0);
            empty_res_reg  <= empty_pend_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last       = last_reg;
    assign empty_res  = empty_res_reg;

endmodule

// ----- rtl/u2d_check.sv -----
module u2d_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [u2d_pkg::VALUE_W-1:0] value,
    input logic [u2d_pkg::WIDTH_W-1:0] min_width,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [u2d_pkg::CHAR_W-1:0]  digit_char,
    input logic                        last,
    input logic                        empty_res
);
    import u2d_pkg::*;

    // A stalled input item stays put until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(value) && $stable(min_width))
        else $error("input item changed under stall");

    // A stalled output item stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digit_char)
            && $stable(last) && $stable(empty_res))
        else $error("output item changed under stall");

    // An empty string's item is always the final one
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last)
        else $error("empty result without last");

    a_empty_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> digit_char == '0)
        else $error("empty result with a nonzero character");

    // Every real character is an ASCII digit
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_res |-> digit_char >= DIGIT_BASE
            && digit_char <= DIGIT_BASE + CHAR_W'(9))
        else $error("character outside '0' to '9'");

endmodule

bind uint_to_decimal_ascii u2d_check u_check (.*);

// ----- verif/tb_top.sv -----
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import u2d_pkg::*;

    localparam int MAX_CHARS   = MAX_CHARS_DEF;
    localparam int IDLE_PCT    = 11;
    // Cycles with no item accepted on either channel before the run is declared hung.
    // The slowest legal gap is the conversion pipeline's own delay plus a run of
    // output stalls, so this leaves a wide margin.
    localparam int HANG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    // One expected character, with the number it came from kept for messages.
    typedef struct {
        logic [CHAR_W-1:0]  ch;
        logic               last;
        logic               empty;
        logic [VALUE_W-1:0] src_value;
        logic [WIDTH_W-1:0] src_width;
    } expected_char_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [VALUE_W-1:0]   value      = '0;
    logic [WIDTH_W-1:0]   min_width  = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [CHAR_W-1:0]    digit_char;
    logic                 last;
    logic                 empty_res;

    // Characters predicted for accepted numbers, oldest first.
    expected_char_t pending_chars[$];

    // Clear to hold both channels busy with no idle or stall cycles.
    bit          idle_en       = 1'b1;
    int unsigned mismatches    = 0;
    int unsigned numbers_sent  = 0;
    int unsigned chars_checked = 0;
    int unsigned empty_strings = 0;
    int unsigned padded_strings = 0;
    int unsigned hang_count    = 0;

    uint_to_decimal_ascii #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .min_width  (min_width),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last),
        .empty_res  (empty_res)
    );

    always #10 clk = ~clk;

    // Output backpressure: stall at random with an 11 percent chance, none while
    // idling is switched off.
    always @(posedge clk)
    begin
        out_stall <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Work out the text of one number and queue its characters.
    // Digits are gathered least significant first, then padded with zeros
    // up to the saturated width, then emitted in reverse.
    function automatic void predict_text(input logic [VALUE_W-1:0] v,
                                         input logic [WIDTH_W-1:0] w);
        logic [3:0]         rev [32];
        logic [VALUE_W-1:0] rem;
        int unsigned        n;
        int unsigned        n_digits;
        int unsigned        wcap;
        expected_char_t     e;
        wcap = (w > MAX_CHARS) ? MAX_CHARS : w;
        rem  = v;
        n    = 0;
        while (rem != 0 && n < MAX_CHARS)
        begin
            rev[n] = 4'(rem % 10);
            rem    = rem / 10;
            n      = n + 1;
        end
        n_digits = n;
        while (n < wcap)
        begin
            rev[n] = 4'd0;
            n      = n + 1;
        end
        if (n > n_digits)
        begin
            padded_strings++;
        end
        e.src_value = v;
        e.src_width = w;
        if (n == 0)
        begin
            // Zero with zero width: a single empty marker.
            e.ch    = '0;
            e.last  = 1'b1;
            e.empty = 1'b1;
            pending_chars.push_back(e);
            empty_strings++;
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                e.ch    = DIGIT_BASE + CHAR_W'(rev[n - 1 - k]);
                e.last  = (k + 1 == n);
                e.empty = 1'b0;
                pending_chars.push_back(e);
            end
        end
    endfunction

    // Print one line per mismatch and count every one.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want, input expected_char_t e);
        mismatches++;
        $display("mismatch at %0t: %s got %0d want %0d (value %0d, min_width %0d)",
                 $realtime, what, got, want, e.src_value, e.src_width);
    endtask

    // Present one number on the input channel, idling at random first, and
    // hold it until the block takes it. The expectation is queued on the
    // accepting edge, well ahead of the first character.
    task automatic send_number(input logic [VALUE_W-1:0] v, input logic [WIDTH_W-1:0] w);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        value     <= v;
        min_width <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_text(v, w);
        numbers_sent++;
    endtask

    // Pick a value: most often a random number of a chosen digit count, plus
    // full-range noise, zeros, tiny values and the edges of each decade.
    function automatic logic [VALUE_W-1:0] random_value();
        longint unsigned lo;
        longint unsigned hi;
        int unsigned     pick;
        int unsigned     digits;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            digits = $urandom_range(1, DIGITS);
            lo = 1;
            for (int i = 1; i < digits; i++)
            begin
                lo = lo * 10;
            end
            hi = (digits == DIGITS) ? 64'hFFFF_FFFF : lo * 10 - 1;
            return VALUE_W'($urandom_range(32'(hi), 32'(lo)));
        end
        else if (pick < 65)
        begin
            return $urandom;
        end
        else if (pick < 80)
        begin
            return '0;
        end
        else if (pick < 90)
        begin
            return VALUE_W'($urandom_range(0, 99));
        end
        else
        begin
            digits = $urandom_range(0, DIGITS - 1);
            lo = 1;
            for (int i = 0; i < digits; i++)
            begin
                lo = lo * 10;
            end
            case ($urandom_range(0, 2))
                0: return VALUE_W'(lo);
                1: return VALUE_W'(lo - 1);
                default: return '1;
            endcase
        end
    endfunction

    // Widths mostly fall from zero to one above the cap, with extra zeros and full-range noise mixed in.
    function automatic logic [WIDTH_W-1:0] random_width();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            return WIDTH_W'($urandom_range(0, MAX_CHARS + 1));
        end
        else if (pick < 75)
        begin
            return '0;
        end
        else
        begin
            return WIDTH_W'($urandom_range(0, 255));
        end
    endfunction

    // Extremes of both fields and every named special case.
    task automatic test_directed_cases();
        send_number(32'd0, 8'd0);             // empty string
        send_number(32'd0, 8'd1);             // single padding zero
        send_number(32'd0, 8'(MAX_CHARS));    // padding only, full length
        send_number(32'd0, 8'(MAX_CHARS + 1)); // width saturates
        send_number(32'd0, 8'd255);
        send_number(32'd1, 8'd0);
        send_number(32'd9, 8'd0);
        send_number(32'd10, 8'd0);
        send_number(32'd99, 8'd2);            // width equal to digit count
        send_number(32'd100, 8'd2);           // width below digit count
        send_number(32'd999_999_999, 8'd0);
        send_number(32'd1_000_000_000, 8'd0);
        send_number(32'hFFFF_FFFF, 8'd0);
        send_number(32'hFFFF_FFFF, 8'd10);
        send_number(32'hFFFF_FFFF, 8'd11);
        send_number(32'hFFFF_FFFF, 8'(MAX_CHARS));
        send_number(32'hFFFF_FFFF, 8'd255);
        send_number(32'd12345, 8'd8);
        send_number(32'd7, 8'd200);
        send_number(32'h8000_0000, 8'h80);
        send_number(32'h5555_5555, 8'h55);
        send_number(32'hAAAA_AAAA, 8'hAA);
        send_number(32'd4_294_967_294, 8'd1);
    endtask

    task automatic test_random_numbers(input int unsigned count);
        repeat (count)
        begin
            send_number(random_value(), random_width());
        end
    endtask

    // Both channels at full rate, subject to in_stall: no input gaps, no output stalls.
    task automatic test_back_to_back(input int unsigned count);
        idle_en = 1'b0;
        repeat (count)
        begin
            send_number(random_value(), random_width());
        end
        idle_en = 1'b1;
    endtask

    // Compare each accepted character with the oldest expectation.
    always @(posedge clk)
    begin : check_output
        expected_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                want = '{default: '0};
                report_mismatch("character with nothing pending, digit_char",
                                32'(digit_char), 0, want);
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (digit_char !== want.ch)
                begin
                    report_mismatch("digit_char", 32'(digit_char), 32'(want.ch), want);
                end
                if (last !== want.last)
                begin
                    report_mismatch("last", 32'(last), 32'(want.last), want);
                end
                if (empty_res !== want.empty)
                begin
                    report_mismatch("empty_res", 32'(empty_res), 32'(want.empty), want);
                end
            end
        end
    end

    // Hang detector: count cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            hang_count <= 0;
        end
        else
        begin
            hang_count <= hang_count + 1;
        end
        if (hang_count >= HANG_LIMIT)
        begin
            $display("hang: no item moved for %0d cycles, %0d characters pending",
                     HANG_LIMIT, pending_chars.size());
            $display("[uint_to_decimal_ascii] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (11)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_numbers(300);
        test_back_to_back(60);
        test_random_numbers(60);

        // Drop valid, then let every queued character drain.
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        // Catch any stray character after the last expected one.
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        $display("converted %0d numbers into %0d checked characters", numbers_sent,
                 chars_checked);
        $display("%0d empty strings, %0d zero-padded strings, %0d mismatches",
                 empty_strings, padded_strings, mismatches);
        if (mismatches == 0)
        begin
            $display("[uint_to_decimal_ascii] OK");
        end
        else
        begin
            $display("[uint_to_decimal_ascii] ERROR");
        end
        $finish;
    end

endmodule
